FILE: hdl/best_fit_partition_allocator_assert.svh
// ----------------------------------------------------------------------------
// best fit partition allocator assertion macros
// concurrent checks on clk; BFPA_ASSERT is disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BFPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFPA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFPA_ASSERT(label, prop, msg)
`define BFPA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: hdl/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// bfpa_pkg
// types and constants of the best fit partition allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bfpa_pkg;

  localparam int DEF_ALLOC_SLOTS = 16;
  localparam int DEF_ADDR_BITS   = 16;
  localparam int CAP_BITS        = 16;
  localparam int PID_BITS        = 8;
  localparam int STATUS_BITS     = 3;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 16'hFFFF;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    STS_OK, STS_NO_FIT, STS_BAD_SIZE, STS_FULL, STS_NOT_FOUND
  } status_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_ACHK, ST_ASCAN, ST_AWR,
    ST_RSCAN, ST_RFSCAN, ST_RFWR, ST_RSHRD, ST_RSHWR
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/best_fit_partition_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_partition_allocator
// best fit variable partition allocator with coalescing on release
// ----------------------------------------------------------------------------
// allocate: one read per cycle scan of the free table memory, with a reject on a bad
//   size or a full table before the scan; release: allocation table scan, free table
//   scan and age-order shift of the allocation table
// concurrency: one transfer in flight, next start accepted at the edge ending the strobe
// reset: synchronous, active low; capacity 65535, seeded into the free table on init
// a capacity write also reseeds the free table through the init state; results cannot stall
`timescale 1ns / 1ps
`default_nettype none
module best_fit_partition_allocator #(
  parameter int ALLOC_SLOTS = bfpa_pkg::DEF_ALLOC_SLOTS,
  parameter int ADDR_BITS   = bfpa_pkg::DEF_ADDR_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_command,
  input  wire logic [bfpa_pkg::PID_BITS-1:0]    in_process_id,
  input  wire logic [bfpa_pkg::CAP_BITS-1:0]    in_request_size,
  output logic                                  out_valid,
  output logic [bfpa_pkg::STATUS_BITS-1:0]      out_status,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bfpa_pkg::CAP_BITS-1:0]    cfg_memory_capacity
);
  import bfpa_pkg::*;

  localparam int AB  = ADDR_BITS;
  localparam int FS  = ALLOC_SLOTS + 1;
  localparam int AIW = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;
  localparam int ACW = $clog2(ALLOC_SLOTS + 1);
  localparam int FIW = $clog2(FS);
  localparam int SCW = $clog2(FS + 1);
  localparam int AEW = 2 * AB + PID_BITS;

  // memories
  logic [2*AB-1:0] free_mem [FS];
  logic [AEW-1:0]  alloc_mem [ALLOC_SLOTS];
  logic [2*AB-1:0] free_rd_q;
  logic [AEW-1:0]  alloc_rd_q;
  logic            free_we, alloc_we;
  logic [FIW-1:0]  free_wa, free_ra;
  logic [AIW-1:0]  alloc_wa, alloc_ra;
  logic [2*AB-1:0] free_wd;
  logic [AEW-1:0]  alloc_wd;

  // registers
  state_t                state_r, state_nxt;
  logic [CAP_BITS-1:0]   cap_r, cap_nxt;
  logic [FS-1:0]         valid_r, valid_nxt;
  logic [ACW-1:0]        cnt_r, cnt_nxt;
  logic [SCW-1:0]        scan_r, scan_nxt;
  logic                  cmd_r, cmd_nxt;
  logic [PID_BITS-1:0]   pid_r, pid_nxt;
  logic [CAP_BITS-1:0]   req_r, req_nxt;
  logic                  found_r, found_nxt;
  logic [FIW-1:0]        best_idx_r, best_idx_nxt;
  logic [AB-1:0]         st_r, st_nxt;
  logic [AB-1:0]         sz_r, sz_nxt;
  logic [AB:0]           end_r, end_nxt;
  logic [AIW-1:0]        m_r, m_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;

  // datapath helpers
  logic [32:0]   cap_ext, mask_ext, cap_clip, req_ext;
  logic [AB-1:0] cap_eff, req_a;
  logic          bad_size, table_full;
  logic [SCW-1:0] pidx;
  logic [FIW-1:0] pidx_f;
  logic [AB-1:0]  f_st, f_sz, a_st, a_sz;
  logic [PID_BITS-1:0] a_pid;
  logic [AB:0]    f_end;
  logic           f_vld, a_cand, a_better, free_end, r_match, r_end;
  logic           mrg_lo, mrg_hi, slot_ok, shift_more, shift_first;
  logic [FIW-1:0] slot_idx;

  assign cap_ext  = 33'(cap_r);
  assign mask_ext = (33'd1 << AB) - 33'd1;
  assign cap_clip = (cap_ext > mask_ext) ? mask_ext : cap_ext;
  assign cap_eff  = cap_clip[AB-1:0];
  assign req_ext  = 33'(req_r);
  assign req_a    = req_ext[AB-1:0];
  assign bad_size   = (req_r == '0) || (req_ext > cap_clip);
  assign table_full = (cnt_r == ACW'(ALLOC_SLOTS));

  assign pidx   = scan_r - SCW'(1);
  assign pidx_f = pidx[FIW-1:0];
  assign f_st   = free_rd_q[2*AB-1:AB];
  assign f_sz   = free_rd_q[AB-1:0];
  assign f_end  = {1'b0, f_st} + {1'b0, f_sz};
  assign f_vld  = (scan_r != '0) && valid_r[pidx_f];
  assign a_cand = f_vld && (f_sz >= req_a);
  assign a_better = !found_r || (f_sz < sz_r) || ((f_sz == sz_r) && (f_st < st_r));
  assign free_end = (scan_r == SCW'(FS));
  assign mrg_lo = f_vld && (f_end == {1'b0, st_r});
  assign mrg_hi = f_vld && !mrg_lo && ({1'b0, f_st} == end_r);

  assign a_st  = alloc_rd_q[AEW-1:AB+PID_BITS];
  assign a_sz  = alloc_rd_q[AB+PID_BITS-1:PID_BITS];
  assign a_pid = alloc_rd_q[PID_BITS-1:0];
  assign r_match = (scan_r != '0) && (a_pid == pid_r);
  assign r_end   = (scan_r == SCW'(cnt_r));
  assign shift_first = (SCW'(m_r) + SCW'(1)) < SCW'(cnt_r);
  assign shift_more  = (SCW'(m_r) + SCW'(2)) < SCW'(cnt_r);

  always_comb begin
    slot_ok  = 1'b0;
    slot_idx = '0;
    for (int i = FS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        slot_ok  = 1'b1;
        slot_idx = FIW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_command == CMD_ALLOC) ? ST_ACHK : ST_RSCAN;
        end else if (cfg_valid) begin
          state_nxt = ST_INIT;
        end
      end
      ST_ACHK: state_nxt = (bad_size || table_full) ? ST_IDLE : ST_ASCAN;
      ST_ASCAN: begin
        if (free_end) begin
          state_nxt = (found_r || a_cand) ? ST_AWR : ST_IDLE;
        end
      end
      ST_AWR: state_nxt = ST_IDLE;
      ST_RSCAN: begin
        if (r_match) begin
          state_nxt = ST_RFSCAN;
        end else if (r_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RFSCAN: if (free_end) state_nxt = ST_RFWR;
      ST_RFWR:   state_nxt = shift_first ? ST_RSHRD : ST_IDLE;
      ST_RSHRD:  state_nxt = ST_RSHWR;
      ST_RSHWR:  state_nxt = shift_more ? ST_RSHRD : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cap_nxt        = cap_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    cmd_nxt        = cmd_r;
    pid_nxt        = pid_r;
    req_nxt        = req_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    st_nxt         = st_r;
    sz_nxt         = sz_r;
    end_nxt        = end_r;
    m_nxt          = m_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    free_we  = 1'b0;
    free_wa  = '0;
    free_wd  = '0;
    free_ra  = scan_r[FIW-1:0];
    alloc_we = 1'b0;
    alloc_wa = '0;
    alloc_wd = alloc_rd_q;
    alloc_ra = scan_r[AIW-1:0];
    case (state_r)
      ST_INIT: begin
        free_we   = 1'b1;
        free_wa   = '0;
        free_wd   = {{AB{1'b0}}, cap_eff};
        valid_nxt = '0;
        valid_nxt[0] = (cap_eff != '0);
        cnt_nxt   = '0;
      end
      ST_IDLE: begin
        scan_nxt  = '0;
        found_nxt = 1'b0;
        if (start) begin
          cmd_nxt = in_command;
          pid_nxt = in_process_id;
          req_nxt = in_request_size;
        end else if (cfg_valid) begin
          cap_nxt = cfg_memory_capacity;
        end
      end
      ST_ACHK: begin
        if (bad_size) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_BAD_SIZE;
        end else if (table_full) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_FULL;
        end
      end
      ST_ASCAN: begin
        scan_nxt = scan_r + SCW'(1);
        if (a_cand && a_better) begin
          found_nxt    = 1'b1;
          best_idx_nxt = pidx_f;
          st_nxt       = f_st;
          sz_nxt       = f_sz;
        end
        if (free_end && !found_r && !a_cand) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_NO_FIT;
        end
      end
      ST_AWR: begin
        free_we  = 1'b1;
        free_wa  = best_idx_r;
        free_wd  = {st_r + req_a, sz_r - req_a};
        if (sz_r == req_a) valid_nxt[best_idx_r] = 1'b0;
        alloc_we = 1'b1;
        alloc_wa = cnt_r[AIW-1:0];
        alloc_wd = {st_r, req_a, pid_r};
        cnt_nxt  = cnt_r + ACW'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = STS_OK;
      end
      ST_RSCAN: begin
        scan_nxt = scan_r + SCW'(1);
        if (r_match) begin
          m_nxt    = pidx[AIW-1:0];
          st_nxt   = a_st;
          sz_nxt   = a_sz;
          end_nxt  = {1'b0, a_st} + {1'b0, a_sz};
          scan_nxt = '0;
        end else if (r_end) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_NOT_FOUND;
        end
      end
      ST_RFSCAN: begin
        scan_nxt = scan_r + SCW'(1);
        if (mrg_lo) begin
          st_nxt = f_st;
          sz_nxt = sz_r + f_sz;
          valid_nxt[pidx_f] = 1'b0;
        end else if (mrg_hi) begin
          sz_nxt = sz_r + f_sz;
          valid_nxt[pidx_f] = 1'b0;
        end
      end
      ST_RFWR: begin
        if (slot_ok) begin
          free_we = 1'b1;
          free_wa = slot_idx;
          free_wd = {st_r, sz_r};
          valid_nxt[slot_idx] = 1'b1;
        end
        if (!shift_first) begin
          cnt_nxt        = cnt_r - ACW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
        end
      end
      ST_RSHRD: begin
        alloc_ra = m_r + AIW'(1);
      end
      ST_RSHWR: begin
        alloc_we = 1'b1;
        alloc_wa = m_r;
        alloc_wd = alloc_rd_q;
        m_nxt    = m_r + AIW'(1);
        if (!shift_more) begin
          cnt_nxt        = cnt_r - ACW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    free_rd_q <= free_mem[free_ra];
  end

  always_ff @(posedge clk) begin
    if (alloc_we) begin
      alloc_mem[alloc_wa] <= alloc_wd;
    end
    alloc_rd_q <= alloc_mem[alloc_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      cnt_r       <= '0;
      scan_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      scan_r      <= scan_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pid_r        <= pid_nxt;
    req_r        <= req_nxt;
    best_idx_r   <= best_idx_nxt;
    st_r         <= st_nxt;
    sz_r         <= sz_nxt;
    end_r        <= end_nxt;
    m_r          <= m_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE) && !start;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  // command latched at start, decoded for the release status check
  logic cmd_rel;
  assign cmd_rel = (cmd_r == CMD_RELEASE);

`include "best_fit_partition_allocator_assert.svh"

  `BFPA_ASSERT(a_strobe_single, out_valid_r |=> !out_valid_r, "back to back result strobes")
  `BFPA_ASSERT(a_cnt_bound, cnt_r <= ACW'(ALLOC_SLOTS), "allocation count past table depth")
  `BFPA_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted transfer did not raise busy")
  `BFPA_ASSERT(a_release_status, (out_valid_r && cmd_rel) |-> (out_status_r == STS_OK || out_status_r == STS_NOT_FOUND), "bad release status")

endmodule
`default_nettype wire

FILE: sim/best_fit_partition_allocator_tb.sv
// ----------------------------------------------------------------------------
// best_fit_partition_allocator_tb
// self-checking bench: a queue-fed driver issues allocate and release requests
// under random idling, a behavioral best fit model predicts each status and a
// monitor compares every result strobe, across several capacity settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module best_fit_partition_allocator_tb;
  import bfpa_pkg::*;

  localparam int SLOTS   = DEF_ALLOC_SLOTS;
  localparam int FSLOTS  = SLOTS + 1;
  localparam int WD_MAX  = 5000;

  typedef struct {
    logic                cmd;
    logic [PID_BITS-1:0] pid;
    logic [CAP_BITS-1:0] size;
  } request_t;

  logic clk, rst_n, start, busy, in_command, out_valid, cfg_valid, cfg_ready;
  logic [PID_BITS-1:0]    in_process_id;
  logic [CAP_BITS-1:0]    in_request_size, cfg_memory_capacity;
  logic [STATUS_BITS-1:0] out_status;

  request_t pending_reqs[$];
  status_t  expected_status[$];
  int       idle_pct, mismatches, quiet_cycles;
  logic     took;

  // model state
  int       capacity;
  bit       blk_valid[FSLOTS];
  int       blk_start[FSLOTS];
  int       blk_size[FSLOTS];
  int       own_start[SLOTS];
  int       own_size[SLOTS];
  int       own_pid[SLOTS];
  int       live_count;

  best_fit_partition_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_process_id(in_process_id),
    .in_request_size(in_request_size), .out_valid(out_valid), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_memory_capacity(cfg_memory_capacity)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic void seed_memory(int cap);
    capacity = cap;
    live_count = 0;
    for (int i = 0; i < FSLOTS; i++) begin
      blk_valid[i] = 1'b0; blk_start[i] = 0; blk_size[i] = 0;
    end
    if (cap != 0) begin
      blk_valid[0] = 1'b1; blk_size[0] = cap;
    end
  endfunction

  function automatic status_t grant_or_free(logic cmd, int pid, int req);
    int best, k, s, z, e, slot;
    best = -1;
    slot = -1;
    if (cmd == CMD_ALLOC) begin
      if (req == 0 || req > capacity) return STS_BAD_SIZE;
      if (live_count >= SLOTS) return STS_FULL;
      for (int i = 0; i < FSLOTS; i++) begin
        if (!blk_valid[i] || blk_size[i] < req) continue;
        if (best < 0 || blk_size[i] < blk_size[best] ||
            (blk_size[i] == blk_size[best] && blk_start[i] < blk_start[best]))
          best = i;
      end
      if (best < 0) return STS_NO_FIT;
      own_start[live_count] = blk_start[best];
      own_size[live_count]  = req;
      own_pid[live_count]   = pid;
      live_count++;
      if (blk_size[best] == req) begin
        blk_valid[best] = 1'b0;
      end else begin
        blk_start[best] += req;
        blk_size[best]  -= req;
      end
      return STS_OK;
    end
    for (k = 0; k < live_count; k++)
      if (own_pid[k] == pid) break;
    if (k >= live_count) return STS_NOT_FOUND;
    s = own_start[k];
    z = own_size[k];
    e = s + z;
    for (int i = 0; i < FSLOTS; i++) begin
      if (!blk_valid[i]) continue;
      if (blk_start[i] + blk_size[i] == s) begin
        s = blk_start[i]; z += blk_size[i]; blk_valid[i] = 1'b0;
      end else if (blk_start[i] == e) begin
        z += blk_size[i]; blk_valid[i] = 1'b0;
      end
    end
    for (int i = 0; i < FSLOTS; i++)
      if (!blk_valid[i] && slot < 0) slot = i;
    if (slot >= 0) begin
      blk_valid[slot] = 1'b1; blk_start[slot] = s; blk_size[slot] = z;
    end
    for (int m = k; m + 1 < live_count; m++) begin
      own_start[m] = own_start[m+1]; own_size[m] = own_size[m+1]; own_pid[m] = own_pid[m+1];
    end
    live_count--;
    return STS_OK;
  endfunction

  // driver
  always @(negedge clk) begin
    request_t r;
    if (rst_n && (!start || took)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        r = pending_reqs.pop_front();
        start <= 1'b1;
        in_command <= r.cmd;
        in_process_id <= r.pid;
        in_request_size <= r.size;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor, model update and watchdog
  always @(posedge clk) begin
    status_t want;
    int      quiet;
    took <= rst_n && start && !busy;
    if (rst_n) begin
      quiet = quiet_cycles + 1;
      if (cfg_valid && cfg_ready) begin
        seed_memory(cfg_memory_capacity);
        quiet = 0;
      end
      if (start && !busy) begin
        expected_status.insert(expected_status.size(),
                               grant_or_free(in_command, in_process_id, in_request_size));
        quiet = 0;
      end
      if (out_valid) begin
        quiet = 0;
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result status %0d", out_status);
        end else begin
          want = expected_status.pop_front();
          if (out_status !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("status mismatch: expected %0d got %0d", want, out_status);
          end
        end
      end
      quiet_cycles <= quiet;
      if (quiet >= WD_MAX) begin
        $display("FAIL best_fit_partition_allocator");
        $finish;
      end
    end
  end

  task automatic push_req(logic cmd, int pid, int size);
    request_t r;
    r.cmd = cmd; r.pid = PID_BITS'(pid); r.size = CAP_BITS'(size);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic drain;
    while (pending_reqs.size() != 0 || start || expected_status.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_capacity(int cap);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_memory_capacity <= CAP_BITS'(cap);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_traffic(int n, int cap);
    int pid, size, span;
    span = (cap / 6 > 1) ? cap / 6 : 1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85) begin
        pid = $urandom_range(7);
        size = $urandom_range(span, 1);
        push_req(($urandom_range(99) < 55) ? CMD_ALLOC : CMD_RELEASE, pid, size);
      end else begin
        push_req(1'($urandom_range(1)), $urandom_range(255), $urandom_range(65535));
      end
    end
  endtask

  initial begin
    int caps[8];
    caps = '{0, 1, 65535, 300, 40000, 2, 1000, 65535};
    rst_n = 1'b0; start = 1'b0; took = 1'b0;
    in_command = CMD_ALLOC; in_process_id = '0; in_request_size = '0;
    cfg_valid = 1'b0; cfg_memory_capacity = '0;
    mismatches = 0; quiet_cycles = 0; idle_pct = 35;
    seed_memory(CAP_RESET);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, exact fit, not found, table full, coalescing
    push_req(CMD_ALLOC, 0, 0);
    push_req(CMD_ALLOC, 255, 65535);
    push_req(CMD_ALLOC, 1, 1);
    push_req(CMD_RELEASE, 9, 0);
    push_req(CMD_RELEASE, 255, 65535);
    for (int i = 0; i < SLOTS; i++) push_req(CMD_ALLOC, i, 100 + i);
    push_req(CMD_ALLOC, 20, 5);
    push_req(CMD_ALLOC, 20, 0);
    push_req(CMD_RELEASE, 3, 0);
    push_req(CMD_RELEASE, 5, 0);
    push_req(CMD_RELEASE, 4, 0);
    drain();

    for (int p = 0; p < 8; p++) begin
      idle_pct = (p < 3) ? 35 : (p < 6) ? 85 : 0;
      write_capacity(caps[p]);
      random_traffic((caps[p] < 3) ? 60 : 290, caps[p]);
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS best_fit_partition_allocator");
    end else begin
      $display("FAIL best_fit_partition_allocator");
    end
    $finish;
  end

endmodule
`default_nettype wire
